### design/rfte_pkg.sv
// rfte_pkg: constants and small decode functions for the RTC-to-epoch converter.
// Depends on nothing; used by rtc_fields_to_epoch_top.
`default_nettype none
package rfte_pkg;

    localparam int unsigned EPOCH_W = 39;
    localparam int unsigned CFG_IDX_W = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BCD_MODE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOUR_24_MODE = 1'd1;

    localparam logic [7:0] PM_MASK       = 8'h80;
    localparam logic [7:0] YEARS_PER_CEN = 8'd100;
    localparam logic [4:0] NOON_HOUR     = 5'd12;

    // 719468 (0000-03-01 to epoch) plus one 400-year era for the +400 year bias.
    localparam logic [23:0] DAYS_OFFSET  = 24'd865565;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [15:0] DAYS_PER_CEN = 16'd36524;
    localparam logic [8:0]  DAYS_PER_YR  = 9'd365;

    // BCD or binary decode of one byte; bcd result is at most 165.
    function automatic logic [7:0] byte_decode(input logic [7:0] b, input logic bcd);
        logic [7:0] tens;
        begin
            tens = 8'({4'd0, b[7:4]} * 8'd10);
            byte_decode = bcd ? 8'(tens + {4'd0, b[3:0]}) : b;
        end
    endfunction

    function automatic logic bcd_digits_ok(input logic [7:0] b);
        bcd_digits_ok = (b[3:0] <= 4'd9) && (b[7:4] <= 4'd9);
    endfunction

    // Day of a March-based year at which each month starts, month 1..12.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        case (m)
            4'd1:    month_start = 9'd306;
            4'd2:    month_start = 9'd337;
            4'd3:    month_start = 9'd0;
            4'd4:    month_start = 9'd31;
            4'd5:    month_start = 9'd61;
            4'd6:    month_start = 9'd92;
            4'd7:    month_start = 9'd122;
            4'd8:    month_start = 9'd153;
            4'd9:    month_start = 9'd184;
            4'd10:   month_start = 9'd214;
            4'd11:   month_start = 9'd245;
            4'd12:   month_start = 9'd275;
            default: month_start = 9'd0;
        endcase
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        case (m)
            4'd2:    month_len = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   month_len = 5'd30;
            default: month_len = 5'd31;
        endcase
    endfunction

endpackage
`default_nettype wire

### design/rtc_fields_to_epoch_top.sv
// rtc_fields_to_epoch_top: raw RTC byte snapshot to Unix epoch seconds, 5-stage pipeline.
// Depends on rfte_pkg (design/rfte_pkg.sv).
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------------
//  snapshot  | start (busy always low) | seconds_raw .. century_raw, 8 bits each
//  result    | done, one-cycle strobe  | epoch_seconds (39b signed), fields_valid
//  config    | cfg_wr_en               | cfg_index (0 bcd_mode, 1 hour_24_mode), cfg_data
//
// Timing: one transaction per clock; done is the output of the last stage register.
// Stages: byte decode, range check and calendar split, day count, days*86400
// multiply, final add. The 24x17 multiply in stage 4 is the deepest path.
// Reset (rst_n low, async) clears the pipeline valid bits and sets bcd_mode=1,
// hour_24_mode=0. The receiver cannot stall, so the pipeline never stops.
// An out-of-range snapshot returns fields_valid=0 and epoch_seconds=0.
`default_nettype none
module rtc_fields_to_epoch_top (
    input  wire  logic                                  clk,
    input  wire  logic                                  rst_n,
    input  wire  logic                                  start,
    output logic                                        busy,
    input  wire  logic [7:0]                            seconds_raw,
    input  wire  logic [7:0]                            minutes_raw,
    input  wire  logic [7:0]                            hours_raw,
    input  wire  logic [7:0]                            day_raw,
    input  wire  logic [7:0]                            month_raw,
    input  wire  logic [7:0]                            year_raw,
    input  wire  logic [7:0]                            century_raw,
    output logic                                        done,
    output logic signed [rfte_pkg::EPOCH_W-1:0]         epoch_seconds,
    output logic                                        fields_valid,
    input  wire  logic                                  cfg_wr_en,
    input  wire  logic [rfte_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  logic                                  cfg_data
);

    // ---------------- configuration registers ----------------
    logic bcd_mode_reg;
    logic hour_24_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_mode_reg     <= 1'b1;
            hour_24_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rfte_pkg::REG_BCD_MODE:     bcd_mode_reg     <= cfg_data;
                rfte_pkg::REG_HOUR_24_MODE: hour_24_mode_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // No stall anywhere: a snapshot is taken every cycle.
    assign busy = 1'b0;

    // ---------------- stage 1: byte decode ----------------
    logic       v1_reg;
    logic [7:0] sec1_reg, min1_reg, hour1_reg, day1_reg, mon1_reg, yr1_reg, cen1_reg;
    logic       pm1_reg, bcd_ok1_reg;
    logic [7:0] hour_strip;
    logic       bcd_ok_next;

    assign hour_strip  = hours_raw & ~rfte_pkg::PM_MASK;
    assign bcd_ok_next = !bcd_mode_reg ||
                         (rfte_pkg::bcd_digits_ok(seconds_raw) &&
                          rfte_pkg::bcd_digits_ok(minutes_raw) &&
                          rfte_pkg::bcd_digits_ok(hour_strip)  &&
                          rfte_pkg::bcd_digits_ok(day_raw)     &&
                          rfte_pkg::bcd_digits_ok(month_raw)   &&
                          rfte_pkg::bcd_digits_ok(year_raw)    &&
                          rfte_pkg::bcd_digits_ok(century_raw));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        sec1_reg    <= rfte_pkg::byte_decode(seconds_raw, bcd_mode_reg);
        min1_reg    <= rfte_pkg::byte_decode(minutes_raw, bcd_mode_reg);
        hour1_reg   <= rfte_pkg::byte_decode(hour_strip, bcd_mode_reg);
        day1_reg    <= rfte_pkg::byte_decode(day_raw, bcd_mode_reg);
        mon1_reg    <= rfte_pkg::byte_decode(month_raw, bcd_mode_reg);
        yr1_reg     <= rfte_pkg::byte_decode(year_raw, bcd_mode_reg);
        cen1_reg    <= rfte_pkg::byte_decode(century_raw, bcd_mode_reg);
        pm1_reg     <= (hours_raw & rfte_pkg::PM_MASK) != 8'd0;
        bcd_ok1_reg <= bcd_ok_next;
    end

    // ---------------- stage 2: range checks, hour fix, calendar split ----------------
    // Year biased by +400 and shifted to a March start: ys = 100*C + Y, Y in 0..99.
    logic       v2_reg, ok2_reg;
    logic [5:0] sec2_reg, min2_reg;
    logic [4:0] hour2_reg;
    logic [6:0] c2_reg, y2_reg;
    logic [8:0] doy2_reg;

    logic       leap, range_ok, hour_ok, mon_ok, day_ok, jan_feb;
    logic [4:0] hour_next;
    logic [6:0] c_next, y_next;

    always_comb
    begin
        // year % 4/100/400 from the split: 100 is a multiple of 4.
        leap = ((yr1_reg[1:0] == 2'd0) && (yr1_reg != 8'd0)) ||
               ((yr1_reg == 8'd0) && (cen1_reg[1:0] == 2'd0));
        range_ok = (sec1_reg <= 8'd59) && (min1_reg <= 8'd59) &&
                   (yr1_reg < rfte_pkg::YEARS_PER_CEN) &&
                   (cen1_reg < rfte_pkg::YEARS_PER_CEN);
        mon_ok = (mon1_reg >= 8'd1) && (mon1_reg <= 8'd12);
        day_ok = (day1_reg >= 8'd1) &&
                 (day1_reg <= {3'd0, rfte_pkg::month_len(mon1_reg[3:0], leap)});

        hour_next = hour1_reg[4:0];
        if (hour_24_mode_reg)
            hour_ok = hour1_reg <= 8'd23;
        else
        begin
            hour_ok = (hour1_reg >= 8'd1) && (hour1_reg <= 8'd12);
            if (hour1_reg[4:0] == rfte_pkg::NOON_HOUR)
                hour_next = pm1_reg ? rfte_pkg::NOON_HOUR : 5'd0;
            else if (pm1_reg)
                hour_next = 5'(hour1_reg[4:0] + rfte_pkg::NOON_HOUR);
        end

        // January and February count with the previous year.
        jan_feb = mon1_reg <= 8'd2;
        if (jan_feb && (yr1_reg == 8'd0))
        begin
            c_next = 7'(cen1_reg + 8'd3);
            y_next = 7'd99;
        end
        else
        begin
            c_next = 7'(cen1_reg + 8'd4);
            y_next = 7'(yr1_reg - {7'd0, jan_feb});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        ok2_reg   <= bcd_ok1_reg && range_ok && hour_ok && mon_ok && day_ok;
        sec2_reg  <= sec1_reg[5:0];
        min2_reg  <= min1_reg[5:0];
        hour2_reg <= hour_next;
        c2_reg    <= c_next;
        y2_reg    <= y_next;
        doy2_reg  <= 9'(rfte_pkg::month_start(mon1_reg[3:0]) + {1'b0, day1_reg} - 9'd1);
    end

    // ---------------- stage 3: day count and second of day ----------------
    // days = 36524*C + 365*Y + Y/4 + C/4 + doy - offset
    logic               v3_reg, ok3_reg;
    logic signed [23:0] days3_reg;
    logic [16:0]        sod3_reg;
    logic [22:0]        days_pos;

    assign days_pos = 23'({7'd0, rfte_pkg::DAYS_PER_CEN} * {16'd0, c2_reg})
                    + 23'({7'd0, rfte_pkg::DAYS_PER_YR} * {9'd0, y2_reg})
                    + 23'(y2_reg[6:2]) + 23'(c2_reg[6:2]) + 23'(doy2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        ok3_reg   <= ok2_reg;
        days3_reg <= signed'({1'b0, days_pos} - rfte_pkg::DAYS_OFFSET);
        sod3_reg  <= 17'({12'd0, hour2_reg} * 17'd3600) + 17'({11'd0, min2_reg} * 17'd60)
                   + {11'd0, sec2_reg};
    end

    // ---------------- stage 4: days * 86400 ----------------
    logic               v4_reg, ok4_reg;
    logic signed [40:0] prod4_reg;
    logic [16:0]        sod4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        ok4_reg   <= ok3_reg;
        prod4_reg <= 41'(days3_reg) * 41'(signed'({1'b0, rfte_pkg::SECS_PER_DAY}));
        sod4_reg  <= sod3_reg;
    end

    // ---------------- stage 5: final add, output register ----------------
    logic                               done_reg, fields_valid_reg;
    logic signed [rfte_pkg::EPOCH_W-1:0] epoch_reg;
    logic [40:0]                        sum5;

    assign sum5 = prod4_reg + 41'({24'd0, sod4_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        fields_valid_reg <= ok4_reg;
        epoch_reg        <= ok4_reg ? signed'(sum5[rfte_pkg::EPOCH_W-1:0]) : '0;
    end

    assign done          = done_reg;
    assign fields_valid  = fields_valid_reg;
    assign epoch_seconds = epoch_reg;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##5 done) else $error("result strobe missing 5 cycles after start");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 5)) else $error("result strobe without a transaction");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !fields_valid |-> epoch_seconds == '0)
        else $error("invalid snapshot with nonzero epoch");

    a_valid_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && fields_valid |-> $past(ok2_reg, 3))
        else $error("valid flag lost track of range check");

endmodule
`default_nettype wire
